// ----- design/astm_frame_builder_defines.svh -----
// assertion macros shared by the frame builder checker
`ifndef ASTM_FRAME_BUILDER_DEFINES_SVH
`define ASTM_FRAME_BUILDER_DEFINES_SVH

// property that must hold in the cycle after the trigger
`define AFB_ASSERT_NEXT(lbl, trig, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error("frame builder check failed");

// property that must hold in the same cycle as the trigger
`define AFB_ASSERT_SAME(lbl, trig, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (prop)) \
    else $error("frame builder check failed");

`endif

// ----- design/afb_pkg.sv -----
// types, constants and helpers for the frame builder
package afb_pkg;

  // control characters of the framing
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_ETB = 8'h17;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // body size limits
  localparam logic [7:0] BODY_LIMIT = 8'd240;
  localparam logic [7:0] BODY_MIN   = 8'd1;

  // default depth of the command queue
  localparam int QUEUE_DEPTH = 4;

  // input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } afb_in_t;

  // output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       message_done;
  } afb_out_t;

  // one classified item: what the back end has to emit
  typedef struct packed {
    logic       do_open;
    logic [7:0] digit;
    logic       do_byte;
    logic [7:0] data;
    logic       do_close;
    logic       is_end;
    logic [7:0] sum;
  } afb_cmd_t;

  // uppercase ascii hex digit
  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    hex_ascii = (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
  endfunction

endpackage

// ----- design/afb_front.sv -----
// front end: config register, frame state and item classification
module afb_front
  import afb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  afb_in_t  in_word_i,
  input  logic     accept_i,
  output logic     push_o,
  output afb_cmd_t cmd_o
);

  logic [7:0] max_body_q, max_body_d;
  logic       in_frame_q, in_frame_d;
  logic [7:0] body_count_q, body_count_d;
  logic [7:0] running_sum_q, running_sum_d;
  logic [2:0] frame_number_q, frame_number_d;

  logic       has, fin;
  logic [7:0] digit, cnt_base, cnt, sum_base, sum_data, term;
  logic       full, do_close;

  // clamp config writes into the legal range
  always_comb begin
    max_body_d = max_body_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == 8'd0) begin
        max_body_d = BODY_MIN;
      end else if (cfg_wdata_i > BODY_LIMIT) begin
        max_body_d = BODY_LIMIT;
      end else begin
        max_body_d = cfg_wdata_i;
      end
    end
  end

  // classify the incoming word
  always_comb begin
    has      = in_word_i.has_byte;
    fin      = in_word_i.end_of_message;
    digit    = CH_ZERO | {5'd0, frame_number_q};
    cnt_base = in_frame_q ? body_count_q : 8'd0;
    if (has && cnt_base != 8'hFF) begin
      cnt = cnt_base + 8'd1;
    end else begin
      cnt = cnt_base;
    end
    sum_base = in_frame_q ? running_sum_q : digit;
    sum_data = has ? (sum_base + in_word_i.data_byte) : sum_base;
    full     = has && !fin && (cnt >= max_body_q);
    do_close = full || fin;
    term     = fin ? CH_ETX : CH_ETB;

    cmd_o.do_open  = !in_frame_q && (has || fin);
    cmd_o.digit    = digit;
    cmd_o.do_byte  = has;
    cmd_o.data     = in_word_i.data_byte;
    cmd_o.do_close = do_close;
    cmd_o.is_end   = fin;
    cmd_o.sum      = sum_data + term;
    push_o         = accept_i && (has || fin);
  end

  // next frame state
  always_comb begin
    in_frame_d     = in_frame_q;
    body_count_d   = body_count_q;
    running_sum_d  = running_sum_q;
    frame_number_d = frame_number_q;
    if (accept_i) begin
      if (do_close) begin
        in_frame_d     = 1'b0;
        body_count_d   = 8'd0;
        running_sum_d  = 8'd0;
        frame_number_d = fin ? 3'd1 : (frame_number_q + 3'd1);
      end else if (has) begin
        in_frame_d    = 1'b1;
        body_count_d  = cnt;
        running_sum_d = sum_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q     <= BODY_LIMIT;
      in_frame_q     <= 1'b0;
      body_count_q   <= 8'd0;
      running_sum_q  <= 8'd0;
      frame_number_q <= 3'd1;
    end else begin
      max_body_q     <= max_body_d;
      in_frame_q     <= in_frame_d;
      body_count_q   <= body_count_d;
      running_sum_q  <= running_sum_d;
      frame_number_q <= frame_number_d;
    end
  end

endmodule

// ----- design/afb_queue.sv -----
// small command queue between front and back end
module afb_queue
  import afb_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  afb_cmd_t cmd_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     valid_o,
  output afb_cmd_t cmd_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  afb_cmd_t        slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- design/afb_back.sv -----
// back end: walks one command through its frame bytes
module afb_back
  import afb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  afb_cmd_t cmd_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output afb_out_t out_word_o
);

  typedef enum logic [2:0] {
    PH_STX, PH_DIGIT, PH_DATA, PH_TERM, PH_HI, PH_LO, PH_CR, PH_LF
  } phase_e;

  phase_e   phase_q, first_ph, next_ph;
  afb_cmd_t cmd_q;
  logic     valid_q;
  logic     is_last, fire, load;

  // sequencing decisions
  always_comb begin
    is_last = (phase_q == PH_LF) || (phase_q == PH_DATA && !cmd_q.do_close);
    fire    = valid_q && !out_stall_i;
    load    = cmd_valid_i && (!valid_q || (fire && is_last));
    pop_o   = load;

    if (cmd_i.do_open) begin
      first_ph = PH_STX;
    end else if (cmd_i.do_byte) begin
      first_ph = PH_DATA;
    end else begin
      first_ph = PH_TERM;
    end

    case (phase_q)
      PH_STX:   next_ph = PH_DIGIT;
      PH_DIGIT: next_ph = cmd_q.do_byte ? PH_DATA : PH_TERM;
      PH_DATA:  next_ph = PH_TERM;
      PH_TERM:  next_ph = PH_HI;
      PH_HI:    next_ph = PH_LO;
      PH_LO:    next_ph = PH_CR;
      PH_CR:    next_ph = PH_LF;
      default:  next_ph = PH_LF;
    endcase
  end

  // output byte select
  always_comb begin
    case (phase_q)
      PH_STX:   out_word_o.out_byte = CH_STX;
      PH_DIGIT: out_word_o.out_byte = cmd_q.digit;
      PH_DATA:  out_word_o.out_byte = cmd_q.data;
      PH_TERM:  out_word_o.out_byte = cmd_q.is_end ? CH_ETX : CH_ETB;
      PH_HI:    out_word_o.out_byte = hex_ascii(cmd_q.sum[7:4]);
      PH_LO:    out_word_o.out_byte = hex_ascii(cmd_q.sum[3:0]);
      PH_CR:    out_word_o.out_byte = CH_CR;
      default:  out_word_o.out_byte = CH_LF;
    endcase
    out_word_o.last_of_run  = is_last;
    out_word_o.message_done = (phase_q == PH_LF) && cmd_q.is_end;
    out_valid_o             = valid_q;
  end

  // state and held command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= PH_STX;
      cmd_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        phase_q <= first_ph;
        cmd_q   <= cmd_i;
      end else if (fire) begin
        if (is_last) begin
          valid_q <= 1'b0;
        end else begin
          phase_q <= next_ph;
        end
      end
    end
  end

endmodule

// ----- design/astm_frame_builder.sv -----
// top level of the frame builder
// a taken item passes through the command queue and the back end's held command before its first byte is valid
// throughput: one output byte per cycle while out_stall_i is low; each item causes
//   no output bytes if it is an idle word, else one to eight
// the command queue lets items be taken while earlier frames still drain
// reset: no frame open, frame number 1, max_body 240, queue and output empty
module astm_frame_builder
  import afb_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  afb_in_t    in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output afb_out_t   out_word_o
);

  logic     q_full, q_valid, push, pop, accept;
  afb_cmd_t push_cmd, pop_cmd;

  // input word taken whenever the queue has room
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  afb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .accept_i    (accept),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  afb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  afb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- design/afb_checker.sv -----
// port level checks for the frame builder, bound to the top level
`include "astm_frame_builder_defines.svh"

module afb_checker
  import afb_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input afb_out_t   out_word_o
);

  // a stalled output word holds
  `AFB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o))

  // the message end marks the final word of its run
  `AFB_ASSERT_SAME(a_done_last, out_valid_o && out_word_o.message_done, out_word_o.last_of_run)

  // the message end sits on a line feed
  `AFB_ASSERT_SAME(a_done_lf, out_valid_o && out_word_o.message_done, out_word_o.out_byte == CH_LF)

endmodule

bind astm_frame_builder afb_checker u_afb_checker (.*);

// ----- tb/tb.sv -----
// self-checking testbench for the astm frame builder
module tb;
  import afb_pkg::*;

  localparam int CycleLimit  = 600000;
  localparam int DrainCycles = 8;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  afb_in_t    in_word_i;
  logic       out_valid_o;
  logic       out_stall_i;
  afb_out_t   out_word_o;

  // framed bytes still owed by the block, oldest first
  afb_out_t   framed_q[$];
  // bytes caused by the word being encoded
  afb_out_t   run_q[$];

  // encoder copy of the block state
  logic [7:0] body_max;
  logic       frame_open;
  logic [7:0] body_len;
  logic [7:0] frame_sum;
  logic [2:0] frame_num;

  int         err_count;
  int         word_count;
  int         cycle_count;
  int         stall_left;
  bit         calm_q;

  astm_frame_builder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb failed");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("mismatch at output word %0d: %s", word_count, msg);
    err_count++;
  endtask

  // idle length: mostly short, a few long
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // ascii uppercase hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      return CH_ZERO + wide;
    end
    return 8'h41 + wide - 8'd10;
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic done);
    afb_out_t t;
    t.out_byte     = b;
    t.last_of_run  = 1'b0;
    t.message_done = done;
    run_q.push_back(t);
  endfunction

  // stx and frame digit
  function automatic void open_frame();
    logic [7:0] digit;
    digit = CH_ZERO + {5'd0, frame_num};
    add_byte(CH_STX, 1'b0);
    add_byte(digit, 1'b0);
    frame_open = 1'b1;
    body_len   = 8'd0;
    frame_sum  = digit;
  endfunction

  // terminator, checksum digits, cr lf
  function automatic void close_frame(input logic [7:0] term);
    logic is_end;
    is_end    = (term == CH_ETX);
    frame_sum = frame_sum + term;
    add_byte(term, 1'b0);
    add_byte(hex_digit(frame_sum[7:4]), 1'b0);
    add_byte(hex_digit(frame_sum[3:0]), 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(CH_LF, is_end);
    frame_open = 1'b0;
    body_len   = 8'd0;
    frame_sum  = 8'd0;
    frame_num  = is_end ? 3'd1 : frame_num + 3'd1;
  endfunction

  // framed bytes for one accepted word
  function automatic void encode_word(input afb_in_t w);
    afb_out_t t;
    run_q.delete();
    if (w.has_byte) begin
      if (!frame_open) open_frame();
      add_byte(w.data_byte, 1'b0);
      frame_sum = frame_sum + w.data_byte;
      if (body_len != 8'hFF) body_len = body_len + 8'd1;
      if (body_len >= body_max && !w.end_of_message) close_frame(CH_ETB);
    end
    if (w.end_of_message) begin
      if (!frame_open) open_frame();
      close_frame(CH_ETX);
    end
    if (run_q.size() > 0) begin
      t = run_q.pop_back();
      t.last_of_run = 1'b1;
      run_q.push_back(t);
    end
    foreach (run_q[i]) framed_q.push_back(run_q[i]);
  endfunction

  // output stall with random gaps
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm_q && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // compare each taken output word with the oldest expected one
  always @(posedge clk_i) begin : check_word
    afb_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (framed_q.size() == 0) begin
        report_error($sformatf("unexpected byte %02h", out_word_o.out_byte));
      end else begin
        want = framed_q.pop_front();
        if (out_word_o.out_byte !== want.out_byte) begin
          report_error($sformatf("out_byte %02h, expected %02h",
                                 out_word_o.out_byte, want.out_byte));
        end
        if (out_word_o.last_of_run !== want.last_of_run) begin
          report_error($sformatf("last_of_run %b, expected %b",
                                 out_word_o.last_of_run, want.last_of_run));
        end
        if (out_word_o.message_done !== want.message_done) begin
          report_error($sformatf("message_done %b, expected %b",
                                 out_word_o.message_done, want.message_done));
        end
      end
      word_count++;
    end
  end

  // send one input word and encode it once taken
  task automatic send_word(input afb_in_t w);
    int gap;
    gap = 0;
    if (!calm_q && $urandom_range(0, 2) == 0) gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    encode_word(w);
  endtask

  task automatic send_fields(input logic [7:0] b, input logic has, input logic fin);
    afb_in_t w;
    w.data_byte      = b;
    w.has_byte       = has;
    w.end_of_message = fin;
    send_word(w);
  endtask

  // hold input until every expected byte is out and the pipe is quiet
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_max_body(input logic [7:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (value == 8'd0) begin
      body_max = BODY_MIN;
    end else if (value > BODY_LIMIT) begin
      body_max = BODY_LIMIT;
    end else begin
      body_max = value;
    end
  endtask

  // every word kind at the reset body size
  task automatic test_basic_messages();
    send_fields(8'hA5, 1'b0, 1'b1);
    send_fields(8'h00, 1'b1, 1'b1);
    send_fields(8'hFF, 1'b1, 1'b1);
    send_fields(8'h5A, 1'b0, 1'b0);
    send_fields(8'h41, 1'b1, 1'b0);
    send_fields(8'h00, 1'b1, 1'b0);
    send_fields(8'h7E, 1'b0, 1'b0);
    send_fields(8'h80, 1'b1, 1'b0);
    send_fields(8'h00, 1'b0, 1'b1);
  endtask

  // one-byte frames, frame digit wrap, empty closing frame
  task automatic test_small_frames();
    write_max_body(8'd1);
    for (int k = 0; k < 9; k++) send_fields(8'(k * 29), 1'b1, 1'b0);
    send_fields(8'hFF, 1'b0, 1'b1);
    send_fields(8'h33, 1'b1, 1'b1);
    write_max_body(8'd0);
    send_fields(8'h01, 1'b1, 1'b0);
    send_fields(8'h02, 1'b1, 1'b1);
    write_max_body(8'd3);
    for (int k = 0; k < 6; k++) send_fields(8'($urandom), 1'b1, 1'b0);
    send_fields(8'h00, 1'b0, 1'b1);
  endtask

  // register above range acts as the limit
  task automatic test_register_clamp();
    write_max_body(8'hFF);
    for (int k = 0; k < 4; k++) send_fields(8'($urandom), 1'b1, 1'b0);
    send_fields(8'h00, 1'b0, 1'b1);
    write_max_body(8'd241);
    for (int k = 0; k < 3; k++) send_fields(8'($urandom), 1'b1, 1'b0);
    send_fields(8'hC3, 1'b1, 1'b1);
  endtask

  // body size lowered below an open frame's length
  task automatic test_lower_mid_frame();
    write_max_body(8'd240);
    for (int k = 0; k < 5; k++) send_fields(8'($urandom), 1'b1, 1'b0);
    write_max_body(8'd2);
    send_fields(8'h99, 1'b1, 1'b0);
    send_fields(8'h66, 1'b1, 1'b1);
  endtask

  // random messages with sprinkled idle words and body size changes
  task automatic test_random_messages();
    int items;
    int msgs;
    int len;
    int pick;
    bit join_end;
    items = 0;
    msgs  = 0;
    while (items < 75) begin
      if (msgs % 3 == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          write_max_body(8'($urandom_range(0, 255)));
        end else if (pick == 1) begin
          write_max_body(BODY_LIMIT);
        end else begin
          write_max_body(8'($urandom_range(1, 8)));
        end
      end
      calm_q = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(13, 30);
      end else begin
        len = $urandom_range(0, 12);
      end
      join_end = $urandom_range(0, 1);
      if (len == 0) join_end = 1'b0;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) send_fields(8'($urandom), 1'b0, 1'b0);
        send_fields(8'($urandom), 1'b1, join_end && (k == len - 1));
        items++;
      end
      if (!join_end) begin
        send_fields(8'($urandom), 1'b0, 1'b1);
        items++;
      end
      msgs++;
      // sender holds off until the output has caught up
      if (msgs == 6) wait_drained();
    end
    calm_q = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 8'd0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_stall_i = 1'b0;
    calm_q      = 1'b0;
    stall_left  = 0;
    err_count   = 0;
    word_count  = 0;
    body_max    = BODY_LIMIT;
    frame_open  = 1'b0;
    body_len    = 8'd0;
    frame_sum   = 8'd0;
    frame_num   = 3'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_messages();
    test_small_frames();
    test_register_clamp();
    test_lower_mid_frame();
    test_random_messages();

    // drain and settle
    in_valid_i <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk_i);
    repeat (4 * DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
